@@ hw/rtl/ipsd_pkg.sv @@
package ipsd_pkg;

  // Field widths fixed by the interface definition.
  localparam int unsigned SpeedW = 15;
  localparam int unsigned ErrW   = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DutyW  = 14;
  localparam int unsigned DivW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Gains carry eight fraction bits.
  localparam int unsigned FracW = 8;

  // Internal datapath widths.
  localparam int unsigned DpW   = ErrW + 1;               // e - e1
  localparam int unsigned DdW   = ErrW + 3;               // e - 2*e1 + e2
  localparam int unsigned BandW = ErrW + DivW + 1;        // e * divisor
  localparam int unsigned SumW  = GainW + DdW + 2;        // sum of three products
  localparam int unsigned CorrW = SumW - FracW;           // correction after shift
  localparam int unsigned AccW  = CorrW + 1;              // held duty plus correction

  typedef logic signed [SpeedW-1:0] speed_t;
  typedef logic signed [ErrW-1:0]   err_t;
  typedef logic [GainW-1:0]         gain_t;
  typedef logic [DutyW-1:0]         duty_t;
  typedef logic [DivW-1:0]          div_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;
  typedef logic [CfgDataW-1:0]      cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP_GAIN  = 3'd0,
    CFG_KI_GAIN  = 3'd1,
    CFG_KD_GAIN  = 3'd2,
    CFG_DUTY_MAX = 3'd3,
    CFG_DB_DIV   = 3'd4
  } cfg_idx_e;

  localparam gain_t KpReset     = 16'd5604;
  localparam gain_t KiReset     = 16'd768;
  localparam gain_t KdReset     = 16'd2304;
  localparam duty_t DutyMaxReset = 14'd10000;
  localparam div_t  DbDivReset  = 8'd50;

  typedef struct packed {
    gain_t kp_gain;
    gain_t ki_gain;
    gain_t kd_gain;
    duty_t duty_max;
    div_t  deadband_divisor;
  } cfg_t;

  typedef struct packed {
    err_t  err;
    duty_t duty;
    logic  applied;
  } calc_res_t;

endpackage

@@ hw/rtl/ipsd_if.sv @@
interface ipsd_in_if import ipsd_pkg::*; ();
  logic   valid;
  logic   ready;
  speed_t target_speed;
  speed_t measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface ipsd_out_if import ipsd_pkg::*; ();
  logic  valid;
  logic  ready;
  duty_t duty;
  logic  correction_applied;

  modport source (output valid, output duty, output correction_applied, input ready);
  modport sink   (input valid, input duty, input correction_applied, output ready);
endinterface

interface ipsd_cfg_if import ipsd_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ipsd_cfg.sv @@
module ipsd_cfg import ipsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipsd_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_KP_GAIN:  cfg_d.kp_gain          = cfg_i.data;
        CFG_KI_GAIN:  cfg_d.ki_gain          = cfg_i.data;
        CFG_KD_GAIN:  cfg_d.kd_gain          = cfg_i.data;
        CFG_DUTY_MAX: cfg_d.duty_max         = cfg_i.data[DutyW-1:0];
        CFG_DB_DIV:   cfg_d.deadband_divisor = cfg_i.data[DivW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain          <= KpReset;
      cfg_q.ki_gain          <= KiReset;
      cfg_q.kd_gain          <= KdReset;
      cfg_q.duty_max         <= DutyMaxReset;
      cfg_q.deadband_divisor <= DbDivReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/ipsd_calc.sv @@
module ipsd_calc import ipsd_pkg::*; (
  input  cfg_t      cfg_i,
  input  speed_t    target_i,
  input  speed_t    measured_i,
  input  err_t      err1_i,
  input  err_t      err2_i,
  input  duty_t     held_i,
  output calc_res_t res_o
);

  err_t                          err;
  logic signed [BandW-1:0]       band_prod;
  logic signed [BandW-1:0]       target_ext;
  logic                          div_zero;
  logic                          err_pos;
  logic                          err_neg;
  logic                          apply;
  logic signed [DpW-1:0]         dp;
  logic signed [DdW-1:0]         dd;
  logic signed [DpW+GainW:0]     mul_p;
  logic signed [ErrW+GainW:0]    mul_i;
  logic signed [DdW+GainW:0]     mul_d;
  logic signed [SumW-1:0]        prod_p;
  logic signed [SumW-1:0]        prod_i;
  logic signed [SumW-1:0]        prod_d;
  logic signed [SumW-1:0]        sum;
  logic signed [SumW-1:0]        sum_adj;
  logic signed [CorrW-1:0]       corr;
  logic signed [AccW-1:0]        acc;

  // Error fits in 16 bits since both speeds are 15-bit signed.
  assign err = ErrW'(target_i) - ErrW'(measured_i);

  // The deadband test e > trunc(t/d) is rewritten as e*d > t for a positive
  // error, and e + trunc(t/d) < 0 as e*d < -t for a negative one. Both hold
  // for either sign of the target, so no divider is needed.
  assign band_prod  = BandW'(err) * $signed({1'b0, cfg_i.deadband_divisor});
  assign target_ext = BandW'(target_i);
  assign div_zero   = (cfg_i.deadband_divisor == '0);
  assign err_pos    = !err[ErrW-1] && (err != '0);
  assign err_neg    = err[ErrW-1];

  assign apply = (err_pos && (div_zero || (band_prod > target_ext))) ||
                 (err_neg && (div_zero || (band_prod < -target_ext)));

  assign dp = DpW'(err) - DpW'(err1_i);
  assign dd = DdW'(err) - (DdW'(err1_i) <<< 1) + DdW'(err2_i);

  // Each product is formed at its natural width, a difference times a gain
  // with a zero sign bit, and only then sign-extended for the sum.
  assign mul_p = dp  * $signed({1'b0, cfg_i.kp_gain});
  assign mul_i = err * $signed({1'b0, cfg_i.ki_gain});
  assign mul_d = dd  * $signed({1'b0, cfg_i.kd_gain});

  assign prod_p = SumW'(mul_p);
  assign prod_i = SumW'(mul_i);
  assign prod_d = SumW'(mul_d);

  assign sum = prod_p + prod_i + prod_d;

  // Dropping the fraction bits truncates toward zero, so a negative sum is
  // biased up by one less than the scale before the arithmetic shift.
  assign sum_adj = sum[SumW-1] ? (sum + SumW'((1 << FracW) - 1)) : sum;
  assign corr    = apply ? CorrW'(sum_adj >>> FracW) : '0;

  assign acc = $signed({{(AccW-DutyW){1'b0}}, held_i}) + AccW'(corr);

  always_comb begin
    res_o.err     = err;
    res_o.applied = apply;
    if (acc[AccW-1]) begin
      res_o.duty = '0;
    end else if (acc > $signed({{(AccW-DutyW){1'b0}}, cfg_i.duty_max})) begin
      res_o.duty = cfg_i.duty_max;
    end else begin
      res_o.duty = acc[DutyW-1:0];
    end
  end

endmodule

@@ hw/rtl/incremental_pid_speed_duty.sv @@
// Incremental (velocity form) PID speed regulator producing one PWM duty
// value that drives both wheels.
//
// Channels: in_i carries one control tick per beat (target and measured
// speed), out_o returns one beat per tick with the new duty and a flag that
// tells whether the error lay outside the deadband. cfg_i writes the gains,
// the duty limit and the deadband divisor; it is always ready and should be
// used only while no tick is in flight.
//
// An accepted input beat goes first into the input register, then through
// one pass of the arithmetic into the output register. Throughput is one
// tick per cycle while the receiver keeps out_o.ready high, set by the single
// arithmetic pass, which both reads and updates the error history and held
// duty in the same cycle.
//
// Reset clears the error history and held duty to zero and loads the default
// gains. When the receiver stalls, the output register holds its beat, the
// input register still takes one more beat, and then in_i.ready drops until
// the output drains.
module incremental_pid_speed_duty import ipsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipsd_in_if.sink     in_i,
  ipsd_out_if.source  out_o,
  ipsd_cfg_if.sink    cfg_i
);

  cfg_t      cfg;
  calc_res_t res;

  // Input register.
  logic   s1_valid_q, s1_valid_d;
  speed_t s1_target_q;
  speed_t s1_measured_q;

  // Output register.
  logic  out_valid_q, out_valid_d;
  duty_t out_duty_q;
  logic  out_applied_q;

  // Controller state: the two previous errors and the held duty.
  err_t  err1_q, err1_d;
  err_t  err2_q, err2_d;
  duty_t held_q, held_d;

  logic out_load;
  logic in_take;

  ipsd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ipsd_calc u_calc (
    .cfg_i      (cfg),
    .target_i   (s1_target_q),
    .measured_i (s1_measured_q),
    .err1_i     (err1_q),
    .err2_i     (err2_q),
    .held_i     (held_q),
    .res_o      (res)
  );

  // The tick in the input register moves on whenever the output register is
  // empty or being drained this cycle; the input side refills behind it.
  assign out_load   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d  = in_take || (s1_valid_q && !out_load);
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
    err1_d      = err1_q;
    err2_d      = err2_q;
    held_d      = held_q;
    // History and duty advance exactly once per tick, as it leaves for the
    // output register, so the next tick sees them in the following cycle.
    if (out_load) begin
      err2_d = err1_q;
      err1_d = res.err;
      held_d = res.duty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      err1_q      <= '0;
      err2_q      <= '0;
      held_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      err1_q      <= err1_d;
      err2_q      <= err2_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_target_q   <= in_i.target_speed;
      s1_measured_q <= in_i.measured_speed;
    end
    if (out_load) begin
      out_duty_q    <= res.duty;
      out_applied_q <= res.applied;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.duty               = out_duty_q;
  assign out_o.correction_applied = out_applied_q;

  // The pending output beat always carries the duty that the next tick
  // will build on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q == held_q))
    else $error("output duty differs from held duty");

  // A tick leaving the input register always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("tick lost between input and output register");

  // The error history shifts by one place per tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (err2_q == $past(err1_q)) && (err1_q == $past(res.err)))
    else $error("error history did not shift");

  // Without a tick the history holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(err1_q) && $stable(err2_q) && $stable(held_q))
    else $error("controller state changed without a tick");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import ipsd_pkg::*;

  // Clock, reset and run-length settings.
  localparam int HalfPeriod   = 6;
  localparam int ResetCycles  = 11;
  localparam int CycleLimit   = 200000;
  // Margin after the last expected duty beat before the block counts as idle.
  localparam int SettleCycles = 3;
  localparam int RandomPhases = 6;
  localparam int PhaseTicks   = 84;
  // The receiver blocks this long during the back-pressure test.
  localparam int LongHold     = 80;

  localparam speed_t SpeedMin = {1'b1, {(SpeedW-1){1'b0}}};
  localparam speed_t SpeedMax = {1'b0, {(SpeedW-1){1'b1}}};
  localparam gain_t  GainTop  = '1;
  localparam duty_t  DutyTop  = '1;
  // Register indexes past the last real register must be ignored by the block.
  localparam cfg_idx_t FirstUnusedIdx = cfg_idx_t'(CFG_DB_DIV + 1);
  localparam cfg_idx_t LastUnusedIdx  = '1;

  // One expected beat on the duty channel.
  typedef struct packed {
    duty_t duty;
    logic  applied;
  } duty_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  ipsd_in_if  tick_if ();
  ipsd_out_if duty_if ();
  ipsd_cfg_if cfg_if ();

  incremental_pid_speed_duty i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if.sink),
    .out_o  (duty_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always #HalfPeriod clk = ~clk;

  // Our own copy of the regulator: configuration, error history and held duty.
  cfg_t  pid_cfg;
  err_t  last_err;
  err_t  prev_err;
  duty_t held_duty;

  // Expected duty beats, oldest first.
  duty_beat_t duty_q[$];

  int  errors;
  int  cycle_count;
  bit  no_idle;     // when set, neither side inserts idle cycles
  int  hold_left;   // cycles the receiver still has to block
  int  ready_gap;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic reset_pid_state();
    pid_cfg   = '{KpReset, KiReset, KdReset, DutyMaxReset, DbDivReset};
    last_err  = '0;
    prev_err  = '0;
    held_duty = '0;
  endtask

  // Registers keep only their own width; unknown indexes change nothing.
  task automatic apply_reg_write(cfg_idx_t idx, cfg_data_t wdata);
    case (idx)
      CFG_KP_GAIN:  pid_cfg.kp_gain          = wdata[GainW-1:0];
      CFG_KI_GAIN:  pid_cfg.ki_gain          = wdata[GainW-1:0];
      CFG_KD_GAIN:  pid_cfg.kd_gain          = wdata[GainW-1:0];
      CFG_DUTY_MAX: pid_cfg.duty_max         = wdata[DutyW-1:0];
      CFG_DB_DIV:   pid_cfg.deadband_divisor = wdata[DivW-1:0];
      default: ;
    endcase
  endtask

  // One control tick of the velocity-form PID. The deadband is the target
  // divided by the divisor, truncated toward zero, and a zero divisor gives
  // no deadband at all. With a negative target the deadband is negative and
  // is used exactly as computed. The gain sum is exact in 64 bits and the
  // eight fraction bits are dropped by truncation toward zero. The clamp
  // runs on every tick, so a lowered duty limit bites at once, and the
  // error history shifts whether or not a correction was applied.
  function automatic duty_beat_t predict_duty(speed_t tgt, speed_t meas);
    int         err;
    int         band;
    longint     d_prop;
    longint     d_deriv;
    longint     gain_sum;
    longint     acc;
    duty_beat_t beat;
    err  = int'(tgt) - int'(meas);
    band = 0;
    if (pid_cfg.deadband_divisor != '0) begin
      band = int'(tgt) / int'(pid_cfg.deadband_divisor);
    end
    beat.applied = ((err > 0) && (err - band > 0)) || ((err < 0) && (err + band < 0));
    acc = longint'(held_duty);
    if (beat.applied) begin
      d_prop   = longint'(err) - longint'(last_err);
      d_deriv  = longint'(err) - 2 * longint'(last_err) + longint'(prev_err);
      gain_sum = longint'(pid_cfg.kp_gain) * d_prop
               + longint'(pid_cfg.ki_gain) * longint'(err)
               + longint'(pid_cfg.kd_gain) * d_deriv;
      acc += gain_sum / 256;
    end
    prev_err = last_err;
    last_err = err_t'(err);
    if (acc > longint'(pid_cfg.duty_max)) begin
      acc = longint'(pid_cfg.duty_max);
    end
    if (acc < 0) begin
      acc = 0;
    end
    held_duty = duty_t'(acc);
    beat.duty = held_duty;
    return beat;
  endfunction

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: a long hold requested by a test wins, then the no-idle mode,
  // otherwise random gaps of low ready. Ready changes at the falling edge.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      duty_if.ready <= 1'b0;
      hold_left--;
    end else if (no_idle) begin
      duty_if.ready <= 1'b1;
    end else if (ready_gap > 0) begin
      duty_if.ready <= 1'b0;
      ready_gap--;
    end else begin
      duty_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        ready_gap = gap_len();
      end
    end
  end

  // Every accepted duty beat is compared with the oldest expectation.
  always @(posedge clk) begin
    duty_beat_t exp_beat;
    if (rst_n && duty_if.valid && duty_if.ready) begin
      if (duty_q.size() == 0) begin
        $display("%0t: duty beat with nothing expected: duty %0d applied %0b",
                 $time, duty_if.duty, duty_if.correction_applied);
        errors++;
      end else begin
        exp_beat = duty_q.pop_front();
        if (duty_if.duty !== exp_beat.duty) begin
          $display("%0t: duty mismatch: expected %0d, actual %0d",
                   $time, exp_beat.duty, duty_if.duty);
          errors++;
        end
        if (duty_if.correction_applied !== exp_beat.applied) begin
          $display("%0t: correction_applied mismatch: expected %0b, actual %0b",
                   $time, exp_beat.applied, duty_if.correction_applied);
          errors++;
        end
      end
    end
  end

  // Offers one tick after an optional idle gap and waits for the handshake.
  // When no gap is drawn, valid simply stays high for the next beat.
  task automatic send_tick(int tgt, int meas);
    int unsigned gap;
    gap = no_idle ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_if.valid          <= 1'b1;
    tick_if.target_speed   <= speed_t'(tgt);
    tick_if.measured_speed <= speed_t'(meas);
    do @(posedge clk); while (!tick_if.ready);
    duty_q.push_back(predict_duty(speed_t'(tgt), speed_t'(meas)));
  endtask

  // Stops offering ticks, waits for every expected beat and lets the
  // pipeline empty, so that the block is idle for register writes.
  task automatic settle_block();
    @(negedge clk);
    tick_if.valid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t wdata);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= wdata;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg_write(idx, wdata);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_defaults();
    write_reg(CFG_KP_GAIN, KpReset);
    write_reg(CFG_KI_GAIN, KiReset);
    write_reg(CFG_KD_GAIN, KdReset);
    write_reg(CFG_DUTY_MAX, DutyMaxReset);
    write_reg(CFG_DB_DIV, DbDivReset);
  endtask

  function automatic int extreme_speed();
    case ($urandom_range(0, 3))
      0:       return int'(SpeedMin);
      1:       return int'(SpeedMax);
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic cfg_data_t pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return GainTop;
      2, 3, 4, 5: return cfg_data_t'($urandom_range(0, 4095));
      default: return cfg_data_t'($urandom);
    endcase
  endfunction

  // Random speeds: four in ten wide open, four in ten near-tracking pairs that probe the
  // deadband edge, some field extremes and some exact matches.
  task automatic random_tick();
    int kind;
    int tgt;
    int meas;
    kind = $urandom_range(0, 9);
    tgt  = int'($urandom_range(0, 32767)) - 16384;
    if (kind < 4) begin
      meas = int'($urandom_range(0, 32767)) - 16384;
    end else if (kind < 8) begin
      meas = tgt + int'($urandom_range(0, 400)) - 200;
      if (meas > int'(SpeedMax)) meas = int'(SpeedMax);
      if (meas < int'(SpeedMin)) meas = int'(SpeedMin);
    end else if (kind == 8) begin
      tgt  = extreme_speed();
      meas = extreme_speed();
    end else begin
      meas = tgt;
    end
    send_tick(tgt, meas);
  endtask

  // Default gains right after reset: zero error, errors inside and outside
  // the deadband, negative targets, and the largest errors of both signs.
  task automatic test_reset_defaults();
    send_tick(0, 0);
    send_tick(1000, 990);
    send_tick(1000, 900);
    send_tick(-1000, -900);
    send_tick(-1000, -1010);
    send_tick(int'(SpeedMax), int'(SpeedMin));
    send_tick(int'(SpeedMin), int'(SpeedMax));
    send_tick(0, 5);
  endtask

  // Extreme register values. Wide data words check that the duty limit and
  // the divisor keep only their own bits; 16'h0100 lands as a zero divisor.
  task automatic test_register_extremes();
    settle_block();
    write_reg(CFG_KP_GAIN, GainTop);
    write_reg(CFG_KI_GAIN, GainTop);
    write_reg(CFG_KD_GAIN, GainTop);
    write_reg(CFG_DUTY_MAX, '1);
    write_reg(CFG_DB_DIV, 16'h0100);
    send_tick(49, 0);
    send_tick(int'(SpeedMax), int'(SpeedMin));
    send_tick(int'(SpeedMin), int'(SpeedMax));
    send_tick(int'(SpeedMax), int'(SpeedMax));
    send_tick(int'(SpeedMax), int'(SpeedMin));

    // The duty is near the top now; a lower limit must clamp it on the very
    // next tick even though that tick applies no correction.
    settle_block();
    write_reg(CFG_DUTY_MAX, 16'd100);
    send_tick(0, 0);

    // Zero gains: a correction is flagged but adds nothing. A divisor of one
    // makes the deadband equal to the target.
    settle_block();
    write_reg(CFG_KP_GAIN, '0);
    write_reg(CFG_KI_GAIN, '0);
    write_reg(CFG_KD_GAIN, '0);
    write_reg(CFG_DB_DIV, 16'd1);
    send_tick(300, -1);
    send_tick(300, 1);

    // Unused indexes are written with all ones after modest gains are set;
    // any aliasing onto a real register shows up in the following ticks.
    settle_block();
    write_reg(CFG_KP_GAIN, 16'd256);
    write_reg(CFG_KI_GAIN, 16'd256);
    write_reg(CFG_KD_GAIN, 16'd128);
    write_reg(CFG_DUTY_MAX, DutyTop);
    write_reg(CFG_DB_DIV, 16'd255);
    for (int idx = FirstUnusedIdx; idx <= LastUnusedIdx; idx++) begin
      write_reg(cfg_idx_t'(idx), '1);
    end
    send_tick(-16384, -16000);
    send_tick(int'(SpeedMax), 0);
    send_tick(0, int'(SpeedMax));
  endtask

  // The receiver blocks for a long stretch while ticks keep coming, so the
  // block fills up and drops its input ready until the duty beats drain.
  task automatic test_backpressure();
    settle_block();
    write_defaults();
    send_tick(500, 400);
    send_tick(500, 450);
    hold_left = LongHold;
    repeat (22) random_tick();
  endtask

  // The sender stops until every expected beat has come, then resumes
  // with the history left where it was.
  task automatic test_drain_pause();
    repeat (12) random_tick();
    settle_block();
    repeat (12) random_tick();
  endtask

  // Several register settings in turn: defaults, everything at the top,
  // then random mixes. Every third phase runs with no idling at all.
  task automatic test_random_phases();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      settle_block();
      no_idle = (phase % 3 == 2);
      if (phase == 0) begin
        write_defaults();
      end else if (phase == 1) begin
        write_reg(CFG_KP_GAIN, GainTop);
        write_reg(CFG_KI_GAIN, GainTop);
        write_reg(CFG_KD_GAIN, GainTop);
        write_reg(CFG_DUTY_MAX, DutyTop);
        write_reg(CFG_DB_DIV, 16'd255);
      end else begin
        write_reg(CFG_KP_GAIN, pick_gain());
        write_reg(CFG_KI_GAIN, pick_gain());
        write_reg(CFG_KD_GAIN, pick_gain());
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_DUTY_MAX, '0);
          1:       write_reg(CFG_DUTY_MAX, DutyTop);
          default: write_reg(CFG_DUTY_MAX, cfg_data_t'($urandom));
        endcase
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_DB_DIV, '0);
          1:       write_reg(CFG_DB_DIV, 16'd1);
          default: write_reg(CFG_DB_DIV, cfg_data_t'($urandom));
        endcase
      end
      repeat (PhaseTicks) random_tick();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    // All block inputs start at known values.
    tick_if.valid          = 1'b0;
    tick_if.target_speed   = '0;
    tick_if.measured_speed = '0;
    duty_if.ready          = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = CFG_KP_GAIN;
    cfg_if.data            = '0;
    errors      = 0;
    cycle_count = 0;
    no_idle     = 1'b0;
    hold_left   = 0;
    ready_gap   = 0;
    reset_pid_state();

    rst_n = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_phases();
    settle_block();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
